### rtl/core/gifd_pkg.sv
// Shared types and constants of the GIF LZW pixel decoder.
`default_nettype none
package gifd_pkg;

  // Code table geometry and entry layout: length [31:20], prefix [19:8], suffix [7:0].
  localparam int TBL_AW = 12;
  localparam int TBL_DEPTH = 4096;
  localparam int ENT_W = 32;
  localparam logic [12:0] TBL_FULL = 13'h1000;
  localparam logic [11:0] NO_PREFIX = 12'hFFF;
  localparam logic [11:0] LEN_MAX = 12'hFFF;
  localparam logic [3:0] MAX_WIDTH = 4'd12;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_REFUSED = 3'd1,
    ST_PIXEL   = 3'd2,
    ST_NEED    = 3'd3,
    ST_DONE    = 3'd4,
    ST_BAD     = 3'd5
  } status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MIN_CODE_SIZE = 3'd0,
    CFG_FRAME_WIDTH   = 3'd1,
    CFG_FRAME_HEIGHT  = 3'd2,
    CFG_FRAME_LEFT    = 3'd3,
    CFG_FRAME_TOP     = 3'd4,
    CFG_INTERLACED    = 3'd5
  } cfg_idx_e;

  // Decoding phase that persists between pulls.
  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_TOP   = 3'd1,
    PH_READ  = 3'd2,
    PH_WALK  = 3'd3,
    PH_DONE  = 3'd4,
    PH_BAD   = 3'd5
  } phase_e;

  // Sequencer states of the controller.
  typedef enum logic [2:0] {
    C_IDLE = 3'd0,
    C_STEP = 3'd1,
    C_LOOK = 3'd2,
    C_PIX  = 3'd3,
    C_DIV  = 3'd4,
    C_OUT  = 3'd5
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    first;
    logic    rd_step;
    logic    key_take;
    logic    set_prev;
    logic    tbl_clear;
    logic    tbl_add;
    logic    key_accept;
    logic    walk_step;
    logic    walk_end;
    logic    xy_dec;
    logic    div_start;
    logic    xy_div;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic held_v;
    logic rd_stall;
    logic rd_end;
    logic key_rdy;
    logic k_clear;
    logic k_stop;
    logic k_ge_cnt;
    logic off_full;
    logic prev_clear;
    logic tbl_full;
    logic chain_zero;
    logic pix_ok;
    logic xy_fast;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

### rtl/core/gifd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gifd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/gifd_div.sv
// Restoring serial divider, one quotient bit per cycle, 16-bit divisor.
`default_nettype none
module gifd_div #(
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [15:0]   divisor_i,
  output logic               done_o,
  output logic    [DW-1:0]   quot_o,
  output logic    [15:0]     rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [15:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [16:0]   shifted, diff;
  logic          ge;

  // One shift-and-subtract step.
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
    rem_d   = ge ? diff[15:0] : shifted[15:0];
    quo_d   = {quo_q[DW-2:0], ge};
  end

  // Control: busy flag, step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### rtl/core/gifd_ctrl.sv
// Controller: handshake, decoding phase and step sequencing.
`default_nettype none
module gifd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  input  wire logic           s_cmd_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  wire logic           m_ready_i,
  input  wire gifd_pkg::stat_t stat_i,
  output gifd_pkg::cmd_t      cmd_o
);

  gifd_pkg::ctrl_state_e state_q, state_d;
  gifd_pkg::phase_e      phase_q, phase_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  assign s_ready_o = (state_q == gifd_pkg::C_IDLE) && !out_valid_q;
  assign m_valid_o = out_valid_q;
  assign accept    = s_valid_i && s_ready_o;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gifd_pkg::C_IDLE;
      phase_q     <= gifd_pkg::PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.res_status = gifd_pkg::ST_TAKEN;

    unique case (state_q)
      gifd_pkg::C_IDLE: begin
        if (accept) begin
          if (s_cmd_i) begin
            state_d = gifd_pkg::C_STEP;
          end else begin
            cmd_o.res_load = 1'b1;
            if (stat_i.held_v || phase_q == gifd_pkg::PH_DONE ||
                phase_q == gifd_pkg::PH_BAD) begin
              cmd_o.res_status = gifd_pkg::ST_REFUSED;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
        end
      end
      gifd_pkg::C_STEP: begin
        unique case (phase_q)
          gifd_pkg::PH_FIRST: begin
            cmd_o.first = 1'b1;
            if (stat_i.key_rdy) begin
              cmd_o.key_take = 1'b1;
              if (stat_i.k_stop) begin
                phase_d = gifd_pkg::PH_DONE;
              end else begin
                cmd_o.set_prev = 1'b1;
                phase_d = gifd_pkg::PH_TOP;
              end
            end else if (stat_i.rd_stall) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = gifd_pkg::ST_NEED;
              state_d = gifd_pkg::C_IDLE;
            end else begin
              cmd_o.rd_step = 1'b1;
              if (stat_i.rd_end) begin
                phase_d = gifd_pkg::PH_DONE;
              end
            end
          end
          gifd_pkg::PH_TOP: begin
            priority if (stat_i.off_full) begin
              phase_d = gifd_pkg::PH_DONE;
            end else if (stat_i.prev_clear) begin
              cmd_o.tbl_clear = 1'b1;
              phase_d = gifd_pkg::PH_READ;
            end else begin
              cmd_o.tbl_add = !stat_i.tbl_full;
              phase_d = gifd_pkg::PH_READ;
            end
          end
          gifd_pkg::PH_READ: begin
            if (stat_i.key_rdy) begin
              cmd_o.key_take = 1'b1;
              priority if (stat_i.k_clear) begin
                cmd_o.set_prev = 1'b1;
                phase_d = gifd_pkg::PH_TOP;
              end else if (stat_i.k_stop) begin
                phase_d = gifd_pkg::PH_DONE;
              end else if (stat_i.k_ge_cnt) begin
                phase_d = gifd_pkg::PH_BAD;
              end else begin
                cmd_o.key_accept = 1'b1;
                phase_d = gifd_pkg::PH_WALK;
                state_d = gifd_pkg::C_LOOK;
              end
            end else if (stat_i.rd_stall) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = gifd_pkg::ST_NEED;
              state_d = gifd_pkg::C_IDLE;
            end else begin
              cmd_o.rd_step = 1'b1;
              if (stat_i.rd_end) begin
                phase_d = gifd_pkg::PH_DONE;
              end
            end
          end
          gifd_pkg::PH_WALK: begin
            if (stat_i.chain_zero) begin
              cmd_o.walk_end = 1'b1;
              phase_d = gifd_pkg::PH_TOP;
            end else begin
              cmd_o.walk_step = 1'b1;
              state_d = gifd_pkg::C_PIX;
            end
          end
          gifd_pkg::PH_DONE: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = gifd_pkg::ST_DONE;
            state_d = gifd_pkg::C_IDLE;
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = gifd_pkg::ST_BAD;
            phase_d = gifd_pkg::PH_BAD;
            state_d = gifd_pkg::C_IDLE;
          end
        endcase
      end
      gifd_pkg::C_LOOK: begin
        state_d = gifd_pkg::C_STEP;
      end
      gifd_pkg::C_PIX: begin
        priority if (!stat_i.pix_ok) begin
          state_d = gifd_pkg::C_STEP;
        end else if (stat_i.xy_fast) begin
          cmd_o.xy_dec = 1'b1;
          state_d = gifd_pkg::C_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = gifd_pkg::C_DIV;
        end
      end
      gifd_pkg::C_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.xy_div = 1'b1;
          state_d = gifd_pkg::C_OUT;
        end
      end
      gifd_pkg::C_OUT: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = gifd_pkg::ST_PIXEL;
        state_d = gifd_pkg::C_IDLE;
      end
      default: begin
        state_d = gifd_pkg::C_IDLE;
      end
    endcase

    // Output register occupancy.
    out_valid_d = out_valid_q;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gifd_dpath.sv
// Datapath: configuration, bit reader, code table, chain walk and pixel placement.
`default_nettype none
module gifd_dpath #(
  parameter int OB = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire logic [7:0]     in_byte_i,
  input  wire gifd_pkg::cmd_t cmd_i,
  output gifd_pkg::stat_t     stat_o,
  output logic      [2:0]     res_status_o,
  output logic      [7:0]     res_pixel_o,
  output logic      [15:0]    res_x_o,
  output logic      [15:0]    res_y_o
);

  localparam int PW = OB + 1;
  localparam logic [PW-1:0] OMAX = {1'b0, {OB{1'b1}}};

  // Configuration registers.
  logic [3:0]  mcs_q;
  logic [15:0] fw_q, fh_q, fl_q, ft_q;
  logic        il_q;

  // Decoder state.
  logic [7:0]  held_q, cur_q, sub_q;
  logic        held_v_q;
  logic [2:0]  bs_q;
  logic [11:0] partial_q;
  logic [3:0]  kb_q, cw_q;
  logic [12:0] cnt_q;
  logic        full_q, grow_q;
  logic [11:0] prev_q, prev_len_q, last_len_q, last_pre_q;
  logic [7:0]  first_suf_q;
  logic [31:0] chain_q;
  logic [11:0] chain_left_q;
  logic [OB-1:0] offset_q;
  logic        lk_pend_q, lk_setlen_q, lk_root_q;
  logic [7:0]  lk_idx_q;

  // Pixel and position state.
  logic [OB-1:0] p_q, cache_p_q;
  logic          pix_ok_q, cache_v_q;
  logic [7:0]    pix_suf_q;
  logic [15:0]   cx_q, cy_q;

  // Combinational helpers.
  logic [3:0]  mcs_eff, w_eff, room, want, frag, kb_next;
  logic [12:0] roots;
  logic [11:0] clear_code, stop_code, key, part_or, pre, len_add;
  logic [7:0]  rdata_byte, fmask, fbits;
  logic [2:0]  bs_next;
  logic        need_len, pre_stop, patch_ok;
  logic [12:0] cnt_n;
  logic [31:0] prod, looked, ram_rdata, ram_wdata;
  logic [32:0] size33;
  logic [OB-1:0] size;
  logic [PW-1:0] p_full, osum;
  logic        ram_we, ram_re;
  logic [11:0] ram_waddr, ram_raddr;
  logic [16:0] h17, n1, n2, n3, y0, y1, y2, y3, ymap;
  logic [15:0] row;
  logic [OB-1:0] quot;
  logic [15:0] rem;
  logic        div_done;

  // Effective code size, root count and the two special codes.
  always_comb begin
    priority if (mcs_q < 4'd2) begin
      mcs_eff = 4'd2;
    end else if (mcs_q > 4'd8) begin
      mcs_eff = 4'd8;
    end else begin
      mcs_eff = mcs_q;
    end
    roots      = 13'(1) << mcs_eff;
    clear_code = roots[11:0];
    stop_code  = roots[11:0] + 12'd1;
    w_eff      = cmd_i.first ? (mcs_eff + 4'd1) : cw_q;
    key        = partial_q & 12'((13'(1) << w_eff) - 13'(1));
  end

  // One fragment of the LSB-first bit reader.
  always_comb begin
    need_len   = (bs_q == 3'd0) && (sub_q == 8'd0);
    rdata_byte = (bs_q == 3'd0) ? held_q : cur_q;
    room       = 4'd8 - {1'b0, bs_q};
    want       = w_eff - kb_q;
    frag       = (want < room) ? want : room;
    fmask      = 8'((9'(1) << frag) - 9'(1));
    fbits      = (rdata_byte >> bs_q) & fmask;
    part_or    = partial_q | 12'({4'b0, fbits} << kb_q);
    kb_next    = kb_q + frag;
    bs_next    = bs_q + frag[2:0];
  end

  // Frame size, pixel position of the current chain entry and offset advance.
  always_comb begin
    prod   = fw_q * fh_q;
    size33 = ({1'b0, prod} > 33'(OMAX)) ? 33'(OMAX) : {1'b0, prod};
    size   = size33[OB-1:0];
    p_full = PW'(offset_q) + PW'(chain_q[31:20]) - PW'(1);
    osum   = PW'(offset_q) + PW'(prev_len_q);
  end

  // Table update values and prefix check.
  always_comb begin
    pre      = chain_q[19:8];
    pre_stop = (pre == gifd_pkg::NO_PREFIX) || ({1'b0, pre} >= cnt_q);
    len_add  = (prev_len_q == gifd_pkg::LEN_MAX) ? gifd_pkg::LEN_MAX : prev_len_q + 12'd1;
    cnt_n    = cnt_q + 13'd1;
    patch_ok = ((13'(prev_q) + 13'd1) < cnt_q) && !full_q;
    looked   = lk_root_q ? {12'd1, gifd_pkg::NO_PREFIX, lk_idx_q} : ram_rdata;
  end

  // Code table port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[11:0];
    ram_wdata = {len_add, prev_q, first_suf_q};
    if (cmd_i.tbl_add) begin
      ram_we = 1'b1;
    end else if (cmd_i.walk_end && patch_ok) begin
      ram_we    = 1'b1;
      ram_waddr = 12'(cnt_q - 13'd1);
      ram_wdata = {last_len_q, last_pre_q, chain_q[7:0]};
    end
    ram_re    = cmd_i.key_accept || (cmd_i.walk_step && !pre_stop);
    ram_raddr = cmd_i.key_accept ? key : pre;
  end

  gifd_ram #(
    .WIDTH(gifd_pkg::ENT_W),
    .DEPTH(gifd_pkg::TBL_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gifd_div #(
    .DW(OB)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(p_q),
    .divisor_i (fw_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // Four-pass interlace row mapping.
  always_comb begin
    h17 = {1'b0, fh_q};
    n1  = (h17 + 17'd7) >> 3;
    n2  = (h17 + 17'd3) >> 3;
    n3  = (h17 + 17'd1) >> 2;
    y0  = {1'b0, cy_q};
    y1  = y0 - n1;
    y2  = y1 - n2;
    y3  = y2 - n3;
    priority if (y0 < n1) begin
      ymap = y0 << 3;
    end else if (y1 < n2) begin
      ymap = (y1 << 3) + 17'd4;
    end else if (y2 < n3) begin
      ymap = (y2 << 2) + 17'd2;
    end else begin
      ymap = (y3 << 1) + 17'd1;
    end
    row = il_q ? ymap[15:0] : cy_q;
  end

  // Status to the controller.
  always_comb begin
    stat_o.held_v     = held_v_q;
    stat_o.rd_stall   = (bs_q == 3'd0) && !held_v_q;
    stat_o.rd_end     = need_len && held_v_q && (held_q == 8'd0);
    stat_o.key_rdy    = kb_q >= w_eff;
    stat_o.k_clear    = key == clear_code;
    stat_o.k_stop     = key == stop_code;
    stat_o.k_ge_cnt   = {1'b0, key} >= cnt_q;
    stat_o.off_full   = offset_q >= size;
    stat_o.prev_clear = prev_q == clear_code;
    stat_o.tbl_full   = full_q;
    stat_o.chain_zero = chain_left_q == 12'd0;
    stat_o.pix_ok     = pix_ok_q;
    stat_o.xy_fast    = cache_v_q && ((p_q == cache_p_q) ||
                        ((PW'(p_q) + PW'(1)) == PW'(cache_p_q)));
    stat_o.div_done   = div_done;
  end

  // Configuration and decoder control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q        <= 4'd8;
      fw_q         <= 16'd1;
      fh_q         <= 16'd1;
      fl_q         <= '0;
      ft_q         <= '0;
      il_q         <= 1'b0;
      held_q       <= '0;
      held_v_q     <= 1'b0;
      bs_q         <= '0;
      sub_q        <= '0;
      partial_q    <= '0;
      kb_q         <= '0;
      cw_q         <= 4'd9;
      cnt_q        <= 13'd258;
      full_q       <= 1'b0;
      grow_q       <= 1'b0;
      prev_q       <= '0;
      prev_len_q   <= '0;
      first_suf_q  <= '0;
      chain_q      <= '0;
      chain_left_q <= '0;
      offset_q     <= '0;
      lk_pend_q    <= 1'b0;
      lk_setlen_q  <= 1'b0;
      cache_v_q    <= 1'b0;
    end else begin
      // Register writes; any write drops the cached pixel position.
      if (cfg_we_i) begin
        cache_v_q <= 1'b0;
        unique case (cfg_idx_i)
          gifd_pkg::CFG_MIN_CODE_SIZE: mcs_q <= cfg_data_i[3:0];
          gifd_pkg::CFG_FRAME_WIDTH:   fw_q  <= cfg_data_i;
          gifd_pkg::CFG_FRAME_HEIGHT:  fh_q  <= cfg_data_i;
          gifd_pkg::CFG_FRAME_LEFT:    fl_q  <= cfg_data_i;
          gifd_pkg::CFG_FRAME_TOP:     ft_q  <= cfg_data_i;
          gifd_pkg::CFG_INTERLACED:    il_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      // Holding register for the offered byte.
      if (cmd_i.push) begin
        held_q   <= in_byte_i;
        held_v_q <= 1'b1;
      end

      // Bit reader: length byte, data fragment or key consumption.
      if (cmd_i.key_take) begin
        partial_q <= '0;
        kb_q      <= '0;
      end else if (cmd_i.rd_step) begin
        if (need_len) begin
          sub_q    <= held_q;
          held_v_q <= 1'b0;
          if (held_q == 8'd0) begin
            partial_q <= '0;
            kb_q      <= '0;
          end
        end else begin
          if (bs_q == 3'd0) begin
            held_v_q <= 1'b0;
            sub_q    <= sub_q - 8'd1;
          end
          partial_q <= part_or;
          kb_q      <= kb_next;
          bs_q      <= bs_next;
        end
      end

      // Code width and table count.
      if (cmd_i.first || cmd_i.tbl_clear) begin
        cw_q  <= mcs_eff + 4'd1;
        cnt_q <= roots + 13'd2;
      end
      if (cmd_i.tbl_clear) begin
        full_q <= 1'b0;
        grow_q <= 1'b0;
      end
      if (cmd_i.tbl_add) begin
        if (cnt_n >= gifd_pkg::TBL_FULL) begin
          cnt_q  <= gifd_pkg::TBL_FULL;
          grow_q <= 1'b0;
          full_q <= 1'b1;
        end else begin
          cnt_q  <= cnt_n;
          grow_q <= (cnt_n & (cnt_n - 13'd1)) == 13'd0;
        end
      end
      if (cmd_i.set_prev) begin
        prev_q <= key;
      end
      if (cmd_i.key_accept) begin
        if (grow_q && cw_q < gifd_pkg::MAX_WIDTH) begin
          cw_q <= cw_q + 4'd1;
        end
        grow_q <= 1'b0;
        prev_q <= key;
      end

      // Table lookups complete in the cycle after issue.
      if (ram_re) begin
        lk_pend_q   <= 1'b1;
        lk_setlen_q <= cmd_i.key_accept;
      end else if (lk_pend_q) begin
        lk_pend_q <= 1'b0;
      end
      if (lk_pend_q) begin
        chain_q <= looked;
        if (lk_setlen_q) begin
          chain_left_q <= looked[31:20];
          prev_len_q   <= looked[31:20];
        end
      end

      // Chain walk and end of string.
      if (cmd_i.walk_step) begin
        if (pre_stop) begin
          chain_left_q <= '0;
        end else begin
          chain_left_q <= chain_left_q - 12'd1;
        end
      end
      if (cmd_i.walk_end) begin
        offset_q    <= (osum > OMAX) ? OMAX[OB-1:0] : osum[OB-1:0];
        first_suf_q <= chain_q[7:0];
      end

      if (cmd_i.xy_dec || cmd_i.xy_div) begin
        cache_v_q <= 1'b1;
      end
    end
  end

  // Lookup source, pixel candidate, cached position and result payload.
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      lk_root_q <= {1'b0, ram_raddr} < roots;
      lk_idx_q  <= ram_raddr[7:0];
    end
    if (cmd_i.rd_step && !need_len && bs_q == 3'd0) begin
      cur_q <= held_q;
    end
    if (cmd_i.tbl_add) begin
      last_len_q <= len_add;
      last_pre_q <= prev_q;
    end
    if (cmd_i.walk_step) begin
      p_q       <= p_full[OB-1:0];
      pix_ok_q  <= (chain_q[31:20] != 12'd0) && (p_full < PW'(size));
      pix_suf_q <= chain_q[7:0];
    end
    if (cmd_i.xy_dec) begin
      cache_p_q <= p_q;
      if (p_q != cache_p_q) begin
        if (cx_q == 16'd0) begin
          cx_q <= fw_q - 16'd1;
          cy_q <= cy_q - 16'd1;
        end else begin
          cx_q <= cx_q - 16'd1;
        end
      end
    end
    if (cmd_i.xy_div) begin
      cache_p_q <= p_q;
      cx_q      <= rem;
      cy_q      <= quot[15:0];
    end
    if (cmd_i.res_load) begin
      res_status_o <= cmd_i.res_status;
      if (cmd_i.res_status == gifd_pkg::ST_PIXEL) begin
        res_pixel_o <= pix_suf_q;
        res_x_o     <= fl_q + cx_q;
        res_y_o     <= ft_q + row;
      end else begin
        res_pixel_o <= '0;
        res_x_o     <= '0;
        res_y_o     <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/gif_lzw_pixel_decoder_core.sv
// Top level of the GIF LZW pixel decoder: controller and datapath.
//
// The block takes the raw image-data bytes of one GIF frame, sub-block length
// bytes included, and returns palette indices placed on the canvas. Each input
// item is a push (tuser 0, one stream byte) or a pull (tuser 1), and each item
// gives exactly one result item. A push is answered in the cycle after it is
// taken. A pull runs the decoder until it yields a pixel, needs a byte, or
// finishes or fails; a code is read one byte fragment at a time, the table is
// updated in a step of its own, and each pixel of a string is fetched from the
// 4096-entry code table memory, which has registered read data. When a pixel
// is not the neighbor of the one before it (the last pixel of every string),
// its column and row come from a serial divider. One item is in work at a
// time; a new item is taken once the result register is free. The code table
// needs no clearing after reset.
`default_nettype none
module gif_lzw_pixel_decoder_core #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // [7:0] pixel_index, [23:8] canvas_x,
                                           // [39:24] canvas_y
  output logic      [2:0]  m_axis_tuser    // [2:0] status
);

  gifd_pkg::cmd_t  cmd;
  gifd_pkg::stat_t stat;
  logic [7:0]      res_pixel;
  logic [15:0]     res_x, res_y;

  gifd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_cmd_i  (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  gifd_dpath #(
    .OB(OFFSET_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_status_o(m_axis_tuser),
    .res_pixel_o (res_pixel),
    .res_x_o     (res_x),
    .res_y_o     (res_y)
  );

  assign m_axis_tdata = {res_y, res_x, res_pixel};

endmodule
`default_nettype wire
